>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 2;
    localparam int BIT_W   = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_SEND_ACK = 3'd4,
        CMD_RECV_ACK = 3'd5
    } t_cmd;

    typedef struct packed {
        logic               is_scl;
        logic               level;
        logic [BYTE_W-1:0]  rd_value;
        logic               last;
        logic [PHASE_W-1:0] nxt_phase;
        logic [BIT_W-1:0]   nxt_bit;
    } t_pin_op;

endpackage

>>> design/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// Decodes one pin write from the command and its phase/bit position.
// ----------------------------------------------------------------------------
module i2cm_step
    import i2cm_pkg::*;
(
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [BIT_W-1:0]   i_bit,
    input  logic [BYTE_W-1:0]  i_tx_byte,
    input  logic               i_ack_out,
    input  logic [BYTE_W-1:0]  i_line_bits,
    input  logic               i_line_ack,
    output t_pin_op            o_op
);

    logic             w_bit_last;
    logic [BIT_W-1:0] w_bit_inc;
    logic [BIT_W-1:0] w_tx_idx;

    assign w_bit_last = (i_bit == {BIT_W{1'b1}});
    assign w_bit_inc  = i_bit + BIT_W'(1);
    assign w_tx_idx   = {BIT_W{1'b1}} - i_bit;

    always_comb begin
        o_op           = '0;
        o_op.nxt_phase = i_phase + PHASE_W'(1);
        o_op.nxt_bit   = i_bit;
        case (t_cmd'(i_cmd))
            CMD_START: begin
                o_op.is_scl = i_phase[0];
                o_op.level  = (i_phase == 2'd0) || (i_phase == 2'd1);
                o_op.last   = (i_phase == 2'd3);
            end
            CMD_STOP: begin
                o_op.is_scl = (i_phase == 2'd1);
                o_op.level  = (i_phase != 2'd0);
                o_op.last   = (i_phase == 2'd2);
            end
            CMD_WRITE: begin
                o_op.is_scl = (i_phase != 2'd0);
                o_op.level  = (i_phase == 2'd0) ? i_tx_byte[w_tx_idx] : (i_phase == 2'd1);
                o_op.last   = (i_phase == 2'd2) && w_bit_last;
                if (i_phase == 2'd2) begin
                    o_op.nxt_phase = 2'd0;
                    o_op.nxt_bit   = w_bit_inc;
                end
            end
            CMD_READ: begin
                o_op.is_scl = (i_phase != 2'd0);
                o_op.level  = (i_phase != 2'd2);
                o_op.last   = (i_phase == 2'd2) && w_bit_last;
                if (o_op.last) begin
                    o_op.rd_value = i_line_bits;
                end
                if (i_phase == 2'd2) begin
                    o_op.nxt_phase = 2'd1;
                    o_op.nxt_bit   = w_bit_inc;
                end
            end
            CMD_SEND_ACK: begin
                o_op.is_scl = (i_phase != 2'd0);
                o_op.level  = (i_phase == 2'd0) ? i_ack_out : (i_phase == 2'd1);
                o_op.last   = (i_phase == 2'd2);
            end
            CMD_RECV_ACK: begin
                o_op.is_scl = (i_phase != 2'd0);
                o_op.level  = (i_phase != 2'd2);
                o_op.last   = (i_phase == 2'd2);
                if (o_op.last) begin
                    o_op.rd_value = {{(BYTE_W-1){1'b0}}, i_line_ack};
                end
            end
            default: begin
                o_op = '0;
            end
        endcase
    end

endmodule

>>> design/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Expands I2C bus commands into the ordered run of SCL/SDA pin writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: start, stop, write byte, read byte,
//   send ack or receive ack, with the byte to send and the sampled SDA levels.
//   m_axis carries one item per pin write: SCL and SDA levels after the write,
//   the read byte / ack bit on the final write of a read, and tlast on the
//   final write of each command.
//   An accepted command goes to the command registers; its first pin write is
//   then registered into the output register. Pin writes follow one per cycle
//   unless m_axis stalls; a command yields 4 (start), 3 (stop, acks), 17 (read)
//   or 24 (write) pin writes, set by the pin-write counter. The next command is
//   accepted as the current command's last pin write is registered, back to back.
//   Unused command codes are accepted and produce no items.
//   Reset: both pins return to released (high), no command pending, output
//   empty. A stall on m_axis holds the output register and the pin-write
//   counter; a command is still accepted while the sequencer is idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // cmd[2:0], tx_byte[10:3], ack_out[11], line_bits[19:12], line_ack[20], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // scl_level[0], sda_level[1], read_value[9:2], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic               r_busy;
    logic [CMD_W-1:0]   r_cmd;
    logic [BYTE_W-1:0]  r_tx_byte;
    logic               r_ack_out;
    logic [BYTE_W-1:0]  r_line_bits;
    logic               r_line_ack;
    logic [PHASE_W-1:0] r_phase;
    logic [BIT_W-1:0]   r_bit;
    logic               r_scl;
    logic               r_sda;

    logic               r_ovalid;
    logic               r_oscl;
    logic               r_osda;
    logic [BYTE_W-1:0]  r_orv;
    logic               r_olast;

    t_pin_op            w_op;
    logic               w_adv;
    logic               w_fire;
    logic               w_accept;
    logic               w_in_valid_cmd;
    logic               n_scl;
    logic               n_sda;

    i2cm_step u_step (
        .i_cmd       (r_cmd),
        .i_phase     (r_phase),
        .i_bit       (r_bit),
        .i_tx_byte   (r_tx_byte),
        .i_ack_out   (r_ack_out),
        .i_line_bits (r_line_bits),
        .i_line_ack  (r_line_ack),
        .o_op        (w_op)
    );

    assign w_adv          = !r_ovalid || m_axis_tready;
    assign w_fire         = r_busy && w_adv;
    assign s_axis_tready  = !r_busy || (w_fire && w_op.last);
    assign w_accept       = s_axis_tvalid && s_axis_tready;
    assign w_in_valid_cmd = (s_axis_tdata[2:0] <= CMD_W'(CMD_RECV_ACK));

    assign n_scl = w_op.is_scl ? w_op.level : r_scl;
    assign n_sda = w_op.is_scl ? r_sda : w_op.level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_ovalid <= 1'b0;
            r_phase  <= '0;
            r_bit    <= '0;
        end else begin
            if (w_fire) begin
                r_scl    <= n_scl;
                r_sda    <= n_sda;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept) begin
                r_busy  <= w_in_valid_cmd;
                r_phase <= '0;
                r_bit   <= '0;
            end else if (w_fire) begin
                r_phase <= w_op.nxt_phase;
                r_bit   <= w_op.nxt_bit;
                if (w_op.last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= s_axis_tdata[2:0];
            r_tx_byte   <= s_axis_tdata[10:3];
            r_ack_out   <= s_axis_tdata[11];
            r_line_bits <= s_axis_tdata[19:12];
            r_line_ack  <= s_axis_tdata[20];
        end
        if (w_fire) begin
            r_oscl  <= n_scl;
            r_osda  <= n_sda;
            r_orv   <= w_op.rd_value;
            r_olast <= w_op.last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(M_TDATA_W-BYTE_W-2){1'b0}}, r_orv, r_osda, r_oscl};
    assign m_axis_tlast  = r_olast;

endmodule

>>> design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
module i2cm_checker
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 m_axis_tlast
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("m_axis payload changed while stalled");

    a_rv_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[9:2] == '0))
        else $error("read_value nonzero before last pin write");

    a_last_bus_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[0] || m_axis_tdata[1])
        else $error("command ended with SCL high and SDA low");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
